### rtl/screen_command_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// screen command frame decoder assertion macros
// immediate-consequence and next-cycle checks on clk, quiet during rst
// ----------------------------------------------------------------------------
`ifndef SCREEN_COMMAND_FRAME_DECODER_MACROS_SVH
`define SCREEN_COMMAND_FRAME_DECODER_MACROS_SVH

// consequence holds in the same cycle
`define SCFD_CHECK(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the following cycle
`define SCFD_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/scfd_pkg.sv
// ----------------------------------------------------------------------------
// scfd_pkg
// shared constants, types and the decimal accumulate step of the decoder
// ----------------------------------------------------------------------------
package scfd_pkg;

  localparam int FRAME_LIMIT = 80;
  localparam int POS_W       = $clog2(FRAME_LIMIT);
  localparam int ACC_W       = 18;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // subcommand letters of a t frame
  localparam logic [7:0] SUB_DRIVE_X  = 8'h78; // x
  localparam logic [7:0] SUB_CENTER_X = 8'h52; // R
  localparam logic [7:0] SUB_DRIVE_Y  = 8'h79; // y
  localparam logic [7:0] SUB_CENTER_Y = 8'h72; // r
  localparam logic [7:0] SUB_GAIN_LO  = 8'h6b; // k
  localparam logic [7:0] SUB_GAIN_HI  = 8'h4b; // K
  localparam logic [7:0] SUB_LINK_ON  = 8'h6f; // o
  localparam logic [7:0] SUB_LINK_OFF = 8'h64; // d
  localparam logic [7:0] SUB_REPORT   = 8'h73; // s

  typedef enum logic [1:0] {
    KIND_MODE     = 2'd0,
    KIND_DISTANCE = 2'd1,
    KIND_ANGLE    = 2'd2,
    KIND_SUBCMD   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    CMD_MODE       = 4'd0,
    CMD_DISTANCE   = 4'd1,
    CMD_ANGLE_DIST = 4'd2,
    CMD_DRIVE_X    = 4'd3,
    CMD_CENTER_X   = 4'd4,
    CMD_DRIVE_Y    = 4'd5,
    CMD_CENTER_Y   = 4'd6,
    CMD_GAIN       = 4'd7,
    CMD_LINK_ON    = 4'd8,
    CMD_LINK_OFF   = 4'd9,
    CMD_REPORT     = 4'd10,
    CMD_UNKNOWN_T  = 4'd11
  } cmd_t;

  // everything the back end needs of one finished frame
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       second_byte;
    logic [7:0]       third_byte;
    logic [7:0]       fourth_byte;
    logic [ACC_W-1:0] first_number;
    logic [ACC_W-1:0] second_number;
    logic             negative;
  } frame_rec_t;

  // acc*10 + c - '0', clamped to the accumulator range
  function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] acc,
                                                input logic [7:0] c);
    logic [ACC_W+4:0] sum;
    logic [ACC_W+4:0] diff;
    sum  = ((ACC_W+5)'(acc) << 3) + ((ACC_W+5)'(acc) << 1) + (ACC_W+5)'(c);
    diff = sum - (ACC_W+5)'(CH_ZERO);
    if (sum < (ACC_W+5)'(CH_ZERO)) begin
      return '0;
    end else if (diff[ACC_W+4:ACC_W] != '0) begin
      return '1;
    end else begin
      return diff[ACC_W-1:0];
    end
  endfunction

endpackage

### rtl/screen_command_frame_decoder.sv
// ----------------------------------------------------------------------------
// screen_command_frame_decoder
// decodes screen link command frames from a byte stream, one result per frame
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_*       in   tdata[7:0] rx_byte
// m_*       out  tuser command; tdata mode_value, launch, value, angle,
//                link_enable, center_x_out, center_y_out
//
// one byte is taken per cycle while s_tready is high; the collector updates in
// the cycle of the beat; a closing '#' queues a frame record, and the result
// shows through the record queue and then a single output register
// the four-entry record queue is what lets bytes keep flowing while m_tready
// is low; s_tready drops only when it is full
// rst is synchronous and clears frame state, link flag and centers
// ----------------------------------------------------------------------------
`include "screen_command_frame_decoder_macros.svh"

module screen_command_frame_decoder import scfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] mode_value, [8] launch, [24:9] value,
                                 // [40:25] angle, [41] link_enable,
                                 // [57:42] center_x_out, [73:58] center_y_out
  output logic [3:0]  m_tuser    // [3:0] command
);

  logic       accept, push, full, pop, not_empty;
  frame_rec_t push_rec, pop_rec;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  scfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .push    (push),
    .rec     (push_rec)
  );

  scfd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_rec   (pop_rec)
  );

  scfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (not_empty),
    .rec       (pop_rec),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  `SCFD_CHECK(a_cmd_range, m_tvalid, m_tuser <= CMD_UNKNOWN_T, "command code out of range")
  `SCFD_CHECK(a_report_unlinks, m_tvalid && m_tuser == CMD_REPORT, !m_tdata[41], "report left link enabled")
  `SCFD_CHECK(a_angle_only_angle, m_tvalid && m_tuser != CMD_ANGLE_DIST, m_tdata[40:25] == '0, "angle on non-angle command")
  `SCFD_CHECK(a_no_push_full, full, !push, "frame record pushed into a full queue")
  `SCFD_CHECK_NEXT(a_pop_shows, pop, m_tvalid, "popped record did not reach the output")

endmodule

### rtl/scfd_front.sv
// ----------------------------------------------------------------------------
// scfd_front
// byte classifier and frame collector; pushes one record per closed frame
// ----------------------------------------------------------------------------
module scfd_front import scfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output frame_rec_t rec
);

  logic             collecting;
  logic [POS_W-1:0] position;
  kind_t            kind;
  logic [7:0]       second_byte, third_byte, fourth_byte;
  logic [ACC_W-1:0] first_number, second_number;
  logic             after_plus, negative;

  logic             collecting_next;
  logic [POS_W-1:0] position_next;
  kind_t            kind_next;
  logic [7:0]       second_byte_next, third_byte_next, fourth_byte_next;
  logic [ACC_W-1:0] first_number_next, second_number_next;
  logic             after_plus_next, negative_next;

  logic             is_start, is_hash, coll_eff;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W:0]   pos_inc;
  kind_t            kind_eff;
  logic [ACC_W-1:0] first_eff, second_eff;
  logic             plus_eff, neg_eff;

  always_comb begin
    is_start = (rx_byte == CH_DOLLAR) || (rx_byte == CH_CARET) ||
               (rx_byte == CH_AMP) || (rx_byte == CH_T);
    is_hash  = (rx_byte == CH_HASH);

    unique case (rx_byte)
      CH_DOLLAR: kind_eff = KIND_MODE;
      CH_CARET:  kind_eff = KIND_DISTANCE;
      CH_AMP:    kind_eff = KIND_ANGLE;
      CH_T:      kind_eff = KIND_SUBCMD;
      default:   kind_eff = kind;
    endcase

    // a start byte restarts the frame before anything else happens
    coll_eff   = is_start | collecting;
    pos_eff    = is_start ? '0 : position;
    first_eff  = is_start ? '0 : first_number;
    second_eff = is_start ? '0 : second_number;
    plus_eff   = is_start ? 1'b0 : after_plus;
    neg_eff    = is_start ? 1'b0 : negative;

    second_byte_next   = second_byte;
    third_byte_next    = third_byte;
    fourth_byte_next   = fourth_byte;
    first_number_next  = first_eff;
    second_number_next = second_eff;
    after_plus_next    = plus_eff;
    negative_next      = neg_eff;
    collecting_next    = coll_eff;
    kind_next          = kind_eff;

    if (coll_eff) begin
      if (pos_eff == POS_W'(1)) begin
        second_byte_next = rx_byte;
      end else if (pos_eff == POS_W'(2)) begin
        third_byte_next = rx_byte;
      end else if (pos_eff == POS_W'(3)) begin
        fourth_byte_next = rx_byte;
      end

      if (!is_start && !is_hash && pos_eff != '0) begin
        if (kind_eff == KIND_DISTANCE) begin
          first_number_next = acc_step(first_eff, rx_byte);
        end else if (kind_eff == KIND_ANGLE) begin
          if (pos_eff == POS_W'(1) && rx_byte == CH_MINUS) begin
            negative_next = 1'b1;
          end else if (!plus_eff && rx_byte == CH_PLUS) begin
            after_plus_next = 1'b1;
          end else if (!plus_eff) begin
            first_number_next = acc_step(first_eff, rx_byte);
          end else begin
            second_number_next = acc_step(second_eff, rx_byte);
          end
        end
      end

      if (is_hash) begin
        collecting_next = 1'b0;
      end
    end

    // frame limit drops a frame that is still open
    pos_inc = {1'b0, pos_eff} + (POS_W+1)'(1);
    if (pos_inc >= (POS_W+1)'(FRAME_LIMIT)) begin
      position_next   = '0;
      collecting_next = 1'b0;
    end else begin
      position_next = pos_inc[POS_W-1:0];
    end
  end

  assign push = accept & collecting & is_hash;

  always_comb begin
    rec.kind          = kind_eff;
    rec.second_byte   = second_byte_next;
    rec.third_byte    = third_byte_next;
    rec.fourth_byte   = fourth_byte_next;
    rec.first_number  = first_number_next;
    rec.second_number = second_number_next;
    rec.negative      = negative_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      position      <= '0;
      kind          <= KIND_MODE;
      second_byte   <= '0;
      third_byte    <= '0;
      fourth_byte   <= '0;
      first_number  <= '0;
      second_number <= '0;
      after_plus    <= 1'b0;
      negative      <= 1'b0;
    end else if (accept) begin
      collecting    <= collecting_next;
      position      <= position_next;
      kind          <= kind_next;
      second_byte   <= second_byte_next;
      third_byte    <= third_byte_next;
      fourth_byte   <= fourth_byte_next;
      first_number  <= first_number_next;
      second_number <= second_number_next;
      after_plus    <= after_plus_next;
      negative      <= negative_next;
    end
  end

endmodule

### rtl/scfd_fifo.sv
// ----------------------------------------------------------------------------
// scfd_fifo
// small frame record queue between the collector and the executor
// ----------------------------------------------------------------------------
module scfd_fifo import scfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output frame_rec_t pop_rec
);

  frame_rec_t         slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full      = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_rec   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      unique case ({push && !full, pop && not_empty})
        2'b10:   count <= count + (FIFO_AW+1)'(1);
        2'b01:   count <= count - (FIFO_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/scfd_back.sv
// ----------------------------------------------------------------------------
// scfd_back
// frame executor: keeps centers and link flag, builds the result beat
// ----------------------------------------------------------------------------
module scfd_back import scfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rec_valid,
  input  frame_rec_t  rec,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,
  output logic [3:0]  m_tuser
);

  logic        link_flag;
  logic [15:0] center_x, center_y;

  logic        link_flag_next;
  logic [15:0] center_x_next, center_y_next;
  cmd_t        cmd;
  logic [7:0]  mode_value;
  logic        launch;
  logic [15:0] value, angle, cx, cy, num;

  assign pop = rec_valid && (!m_tvalid || m_tready);

  always_comb begin
    link_flag_next = link_flag;
    center_x_next  = center_x;
    center_y_next  = center_y;
    cmd            = CMD_UNKNOWN_T;
    mode_value     = '0;
    launch         = 1'b0;
    value          = '0;
    angle          = '0;
    cx             = '0;
    cy             = '0;
    num            = {rec.fourth_byte, rec.third_byte};

    unique case (rec.kind)
      KIND_MODE: begin
        cmd        = CMD_MODE;
        mode_value = rec.second_byte - CH_ZERO;
        launch     = (rec.second_byte == CH_F);
      end
      KIND_DISTANCE: begin
        cmd   = CMD_DISTANCE;
        value = (rec.first_number[ACC_W-1:16] != '0) ? 16'hffff : rec.first_number[15:0];
      end
      KIND_ANGLE: begin
        cmd   = CMD_ANGLE_DIST;
        value = (rec.second_number[ACC_W-1:16] != '0) ? 16'hffff
                                                       : rec.second_number[15:0];
        if (rec.negative) begin
          angle = (rec.first_number[ACC_W-1:15] != '0) ? 16'h8000
                                                        : 16'(-rec.first_number[15:0]);
        end else begin
          angle = (rec.first_number[ACC_W-1:15] != '0) ? 16'h7fff
                                                        : rec.first_number[15:0];
        end
      end
      KIND_SUBCMD: begin
        unique case (rec.second_byte)
          SUB_DRIVE_X: begin
            cmd   = CMD_DRIVE_X;
            value = num;
          end
          SUB_CENTER_X: begin
            cmd           = CMD_CENTER_X;
            value         = num;
            center_x_next = num;
          end
          SUB_DRIVE_Y: begin
            cmd   = CMD_DRIVE_Y;
            value = num;
          end
          SUB_CENTER_Y: begin
            cmd           = CMD_CENTER_Y;
            value         = num;
            center_y_next = num;
          end
          SUB_GAIN_LO, SUB_GAIN_HI: begin
            cmd   = CMD_GAIN;
            value = num;
          end
          SUB_LINK_ON: begin
            cmd            = CMD_LINK_ON;
            link_flag_next = 1'b1;
          end
          SUB_LINK_OFF: begin
            cmd            = CMD_LINK_OFF;
            link_flag_next = 1'b0;
          end
          SUB_REPORT: begin
            // report shows the centers and leaves the link disabled
            cmd            = CMD_REPORT;
            cx             = center_x;
            cy             = center_y;
            link_flag_next = 1'b0;
          end
          default: cmd = CMD_UNKNOWN_T;
        endcase
      end
      default: cmd = CMD_UNKNOWN_T;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_flag <= 1'b0;
      center_x  <= '0;
      center_y  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (pop) begin
        link_flag <= link_flag_next;
        center_x  <= center_x_next;
        center_y  <= center_y_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tuser <= cmd;
      m_tdata <= {6'd0, cy, cx, link_flag_next, angle, value, launch, mode_value};
    end
  end

endmodule
